FILE: hdl/cpfa_pkg.sv
// Package for the cell pair force accumulator.
// Holds the sequencer state type, register indexes and shared constants.
package cpfa_pkg;

    localparam int unsigned OneQ16 = 65536;

    localparam logic [63:0] TermCap = 64'h4000_0000_0000_0000;
    localparam logic [63:0] SumMax  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SumMin  = 64'h8000_0000_0000_0000;

    localparam logic [0:0] RegRemoteGain    = 1'b0;
    localparam logic [0:0] RegRepulsionGain = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_ATTR,
        S_CMP,
        S_SQRT,
        S_DIV,
        S_T2,
        S_REP,
        S_SCALE,
        S_OUT,
        S_HOLD
    } t_state;

endpackage

FILE: hdl/cpfa_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Uses no package items; instantiated by the force accumulator top.
module cpfa_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // One product per cycle, registered before use.
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: hdl/cell_pair_force_accumulator_top.sv
// Cell pair force accumulator: a command 0 transaction loads the target cell and clears the
// sums; each command 1 transaction adds one neighbour. A transaction with last set produces
// one force result. The block handles one transaction at a time and holds ready low meanwhile.
// A neighbour keeps it busy after acceptance for the differences and the passes through
// the single shared 32x32 multiplier, a 32-step square root, and a 48-step divider with a
// setup step. With last set, gain scaling follows, after a neighbour or after a load, and
// the result is offered when it ends; ready returns in the cycle after the result is taken.
// Depends on cpfa_pkg and cpfa_mul.
module cell_pair_force_accumulator_top
    import cpfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_radius,
    input  logic [30:0] i_mass,
    input  logic        i_alive,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_force_x,
    output logic [47:0] o_force_y,
    output logic [47:0] o_force_z,
    output logic        o_saturated
);

    t_state r_state, n_state;

    logic [31:0] r_remote_gain, r_repulsion_gain;
    logic signed [31:0] r_tpos [3];
    logic [30:0] r_trad, r_tmass;
    logic        r_talive, r_clip;
    logic [63:0] r_attr [3];
    logic [63:0] r_rep [3];

    // Latched neighbour transaction.
    logic signed [31:0] r_npos [3];
    logic [30:0] r_nrad, r_nmass;
    logic        r_nalive, r_last;

    // Working registers.
    logic [32:0] r_dmag [3];
    logic        r_dneg [3];
    logic [1:0]  r_idx;
    logic [2:0]  r_ph;
    logic [5:0]  r_cnt;
    logic [65:0] r_acc;
    logic [95:0] r_wide;
    logic [63:0] r_rad;
    logic [63:0] r_root;
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_t2;
    logic        r_sel;
    logic [63:0] r_sterm;
    logic [47:0] r_frc [3];
    logic        r_out_clip;

    logic [31:0] m_a, m_b;
    logic [63:0] m_p;

    cpfa_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p));

    logic [32:0] rsum;
    logic [31:0] msum;
    logic [63:0] sq_trial;
    logic [63:0] sel_sum;
    logic [31:0] sel_gain;
    logic [64:0] sum_mag;
    logic [33:0] div_trial;
    logic [32:0] t_val;

    assign rsum = 33'(r_trad) + 33'(r_nrad);
    assign msum = 32'(r_tmass) + 32'(r_nmass);
    assign t_val = 33'(OneQ16) - 33'(r_quo);
    assign sel_sum  = r_sel ? r_rep[r_idx] : r_attr[r_idx];
    assign sel_gain = r_sel ? r_repulsion_gain : r_remote_gain;
    assign sum_mag  = sel_sum[63] ? 65'(~sel_sum) + 65'd1 : 65'(sel_sum);
    assign sq_trial = r_root | (64'd1 << {r_cnt[4:0], 1'b0});
    assign div_trial = {r_rem, r_wide[47]};

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_HOLD);
    assign o_force_x = r_frc[0];
    assign o_force_y = r_frc[1];
    assign o_force_z = r_frc[2];
    assign o_saturated = r_out_clip;

    // Multiplier operand selection by sequencer state and phase.
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_SQ: begin
                m_a = r_dmag[r_idx][31:0];
                m_b = r_dmag[r_idx][31:0];
            end
            S_ATTR: begin
                m_a = r_dmag[r_idx][31:0];
                m_b = msum;
            end
            S_CMP: begin
                m_a = rsum[31:0];
                m_b = rsum[31:0];
            end
            S_T2: begin
                m_a = t_val[31:0];
                m_b = t_val[31:0];
            end
            S_REP: begin
                m_a = r_dmag[r_idx][31:0];
                m_b = r_t2;
            end
            S_SCALE: begin
                m_a = r_ph[0] ? sum_mag[63:32] : sum_mag[31:0];
                m_b = sel_gain;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = i_command ? S_DIFF : (i_last ? S_SCALE : S_IDLE);
            S_DIFF: n_state = S_SQ;
            S_SQ: if (r_idx == 2'd2 && r_ph == 3'd1) n_state = S_ATTR;
            S_ATTR: if (r_idx == 2'd2 && r_ph == 3'd1) n_state = S_CMP;
            S_CMP: if (r_ph == 3'd2) n_state = S_SQRT;
            S_SQRT: if (r_cnt == 6'd0) n_state = S_DIV;
            S_DIV: if (r_cnt == 6'd0) n_state = S_T2;
            S_T2: if (r_ph == 3'd1) n_state = S_REP;
            S_REP: if (r_idx == 2'd2 && r_ph == 3'd1) n_state = r_last ? S_SCALE : S_IDLE;
            S_SCALE: if (r_idx == 2'd2 && r_sel && r_ph == 3'd3) n_state = S_OUT;
            S_OUT: n_state = S_HOLD;
            S_HOLD: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_gain    <= 32'(OneQ16);
            r_repulsion_gain <= 32'(OneQ16);
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegRemoteGain) r_remote_gain <= i_cfg_data;
            else r_repulsion_gain <= i_cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_tpos[k] <= '0;
                r_attr[k] <= '0;
                r_rep[k]  <= '0;
            end
            r_trad   <= '0;
            r_tmass  <= '0;
            r_talive <= 1'b0;
            r_clip   <= 1'b0;
            r_idx    <= '0;
            r_ph     <= '0;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_ph  <= '0;
                    r_sel <= 1'b0;
                    r_acc <= '0;
                    for (int k = 0; k < 3; k++) r_frc[k] <= '0;
                    r_out_clip <= (i_valid && !i_command) ? 1'b0 : r_clip;
                    if (i_valid) begin
                        r_npos[0] <= i_pos_x;
                        r_npos[1] <= i_pos_y;
                        r_npos[2] <= i_pos_z;
                        r_nrad    <= i_radius;
                        r_nmass   <= i_mass;
                        r_nalive  <= i_alive;
                        r_last    <= i_last;
                        if (!i_command) begin
                            r_tpos[0] <= i_pos_x;
                            r_tpos[1] <= i_pos_y;
                            r_tpos[2] <= i_pos_z;
                            r_trad   <= i_radius;
                            r_tmass  <= i_mass;
                            r_talive <= i_alive;
                            r_clip   <= 1'b0;
                            for (int k = 0; k < 3; k++) begin
                                r_attr[k] <= '0;
                                r_rep[k]  <= '0;
                            end
                        end
                    end
                end
                S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        logic signed [32:0] d;
                        d = 33'(r_tpos[k]) - 33'(r_npos[k]);
                        r_dneg[k] <= d[32];
                        r_dmag[k] <= d[32] ? 33'(-d) : 33'(d);
                    end
                end
                S_SQ: begin
                    // Phase 0 issues, phase 1 adds; the bit-32 magnitude case is handled
                    // by the cross terms of (2^32 + m)^2 = 2^64 + 2^33 m + m^2.
                    if (r_ph == 3'd0) r_ph <= 3'd1;
                    else begin
                        logic [65:0] sq;
                        sq = r_dmag[r_idx][32]
                           ? (66'd1 << 64) + (66'(r_dmag[r_idx][31:0]) << 33) + 66'(m_p)
                           : 66'(m_p);
                        r_acc <= r_acc + sq;
                        r_ph  <= 3'd0;
                        r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                    end
                end
                S_ATTR: begin
                    if (r_ph == 3'd0) r_ph <= 3'd1;
                    else begin
                        if (r_talive && r_nalive) begin
                            logic [64:0] pm;
                            logic [64:0] mg;
                            logic signed [65:0] s;
                            pm = r_dmag[r_idx][32] ? 65'(m_p) + (65'(msum) << 32) : 65'(m_p);
                            mg = pm >> 16;
                            s = r_dneg[r_idx] ? $signed({r_attr[r_idx][63], r_attr[r_idx][63],
                                    r_attr[r_idx]}) + $signed({1'b0, mg})
                                : $signed({r_attr[r_idx][63], r_attr[r_idx][63],
                                    r_attr[r_idx]}) - $signed({1'b0, mg});
                            if (s > $signed({2'b00, SumMax})) begin
                                r_attr[r_idx] <= SumMax; r_clip <= 1'b1;
                            end else if (s < $signed({2'b11, SumMin})) begin
                                r_attr[r_idx] <= SumMin; r_clip <= 1'b1;
                            end else r_attr[r_idx] <= s[63:0];
                        end
                        r_ph  <= 3'd0;
                        r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                    end
                end
                S_CMP: begin
                    // Square of the radius sum, including the carry bit.
                    if (r_ph == 3'd0) r_ph <= 3'd1;
                    else if (r_ph == 3'd1) begin
                        logic [65:0] rr;
                        rr = rsum[32] ? (66'd1 << 64) + (66'(rsum[31:0]) << 33) + 66'(m_p)
                                      : 66'(m_p);
                        r_sel <= (r_acc < rr);
                        r_ph  <= 3'd2;
                        r_rad <= r_acc[63:0];
                        r_root <= '0;
                        r_cnt <= 6'd31;
                    end else begin
                        r_ph <= 3'd0;
                        r_cnt <= 6'd31;
                    end
                end
                S_SQRT: begin
                    // One result bit per cycle, restoring square root.
                    if (r_rad >= sq_trial) begin
                        r_rad  <= r_rad - sq_trial;
                        r_root <= (r_root >> 1) | (64'd1 << {r_cnt[4:0], 1'b0});
                    end else r_root <= r_root >> 1;
                    // The divider starts with a setup step marked by a count of 48.
                    if (r_cnt == 6'd0) r_cnt <= 6'd48;
                    else r_cnt <= r_cnt - 6'd1;
                end
                S_DIV: begin
                    // Restoring divide of (dist << 16) by the radius sum, one bit a cycle.
                    if (r_cnt == 6'd48) begin
                        r_wide <= 96'({r_root[31:0], 16'd0});
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= 6'd47;
                    end else begin
                        if (div_trial >= 34'(rsum)) begin
                            r_rem <= 33'(div_trial - 34'(rsum));
                            r_quo <= {r_quo[46:0], 1'b1};
                        end else begin
                            r_rem <= div_trial[32:0];
                            r_quo <= {r_quo[46:0], 1'b0};
                        end
                        r_wide <= r_wide << 1;
                        if (r_cnt == 6'd0) r_ph <= 3'd0;
                        else r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_T2: begin
                    if (r_ph == 3'd0) r_ph <= 3'd1;
                    else begin
                        r_t2 <= 32'(m_p >> 16);
                        r_ph <= 3'd0;
                        r_idx <= '0;
                    end
                end
                S_REP: begin
                    if (r_ph == 3'd0) r_ph <= 3'd1;
                    else begin
                        if (r_sel) begin
                            logic [64:0] pm;
                            logic [64:0] mg;
                            logic signed [65:0] s;
                            pm = r_dmag[r_idx][32] ? 65'(m_p) + (65'(r_t2) << 32) : 65'(m_p);
                            mg = pm >> 16;
                            s = r_dneg[r_idx] ? $signed({r_rep[r_idx][63], r_rep[r_idx][63],
                                    r_rep[r_idx]}) - $signed({1'b0, mg})
                                : $signed({r_rep[r_idx][63], r_rep[r_idx][63],
                                    r_rep[r_idx]}) + $signed({1'b0, mg});
                            if (s > $signed({2'b00, SumMax})) begin
                                r_rep[r_idx] <= SumMax; r_clip <= 1'b1;
                            end else if (s < $signed({2'b11, SumMin})) begin
                                r_rep[r_idx] <= SumMin; r_clip <= 1'b1;
                            end else r_rep[r_idx] <= s[63:0];
                        end
                        r_ph  <= 3'd0;
                        r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        r_sel <= (r_idx == 2'd2) ? 1'b0 : r_sel;
                        r_out_clip <= r_clip;
                        for (int k = 0; k < 3; k++) r_frc[k] <= '0;
                    end
                end
                S_SCALE: begin
                    // Phases: 0 issue low half, 1 issue high half and keep low product,
                    // 2 combine, 3 clamp and add into the force on the repulsion pass.
                    unique case (r_ph)
                        3'd0: begin
                            // The first pass picks up every accumulator clip so far.
                            if (r_idx == 2'd0 && !r_sel) r_out_clip <= r_clip;
                            r_ph <= 3'd1;
                        end
                        3'd1: begin
                            r_wide <= 96'(m_p);
                            r_ph <= 3'd2;
                        end
                        3'd2: begin
                            r_wide <= r_wide + (96'(m_p) << 32);
                            r_ph <= 3'd3;
                        end
                        default: begin
                            logic [79:0] v;
                            logic [63:0] val;
                            logic signed [65:0] f;
                            logic use_it;
                            logic clipped;
                            v = r_wide[95:16];
                            use_it = r_sel || r_talive;
                            clipped = use_it && (v > 80'(TermCap));
                            val = (v > 80'(TermCap)) ? TermCap : v[63:0];
                            if (!use_it) val = '0;
                            f = sel_sum[63] ? -$signed({2'b00, val}) : $signed({2'b00, val});
                            if (!r_sel) r_acc <= 66'(f);
                            else begin
                                f = f + $signed(r_acc);
                                if (f > 66'sd140737488355327) begin
                                    r_frc[r_idx] <= 48'h7FFF_FFFF_FFFF;
                                    clipped = 1'b1;
                                end else if (f < -66'sd140737488355328) begin
                                    r_frc[r_idx] <= 48'h8000_0000_0000;
                                    clipped = 1'b1;
                                end else r_frc[r_idx] <= f[47:0];
                            end
                            if (clipped) r_out_clip <= 1'b1;
                            r_ph <= 3'd0;
                            r_sel <= !r_sel;
                            if (r_sel) r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // The result is only offered once its last component is written.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("result offered without completing scaling");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !i_ready) |=> $stable(o_force_x) && $stable(o_saturated))
        else $error("result changed while stalled");

endmodule
